@@ hdl/mpdg_pkg.sv @@
package mpdg_pkg;

    localparam int unsigned MaxVertices = 64;
    localparam int unsigned VtxBits     = 6;
    localparam int unsigned WeightBits  = 32;
    localparam int unsigned EdgeBits    = 2 * VtxBits;

    typedef logic [VtxBits-1:0]    t_vtx;
    typedef logic [WeightBits-1:0] t_weight;

    typedef enum logic [1:0] {
        OP_START_LIST = 2'd0,
        OP_ADD_EDGE   = 2'd1,
        OP_RUN_TREE   = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  from_vertex;
        logic [5:0]  to_vertex;
        logic [31:0] edge_cost;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  tree_parent;
        logic [5:0]  tree_child;
        logic [31:0] tree_cost;
        logic        edge_valid;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_EMIT,
        ST_DONE,
        ST_ACK,
        ST_CLEAR
    } t_state;

endpackage

@@ hdl/mst_prim_dense_graph_unit.sv @@
// prim minimum spanning tree engine over a dense directed graph of up to 64 vertices
// input channel: i_in_valid / o_in_stall with payload i_in_item; output channel:
// o_out_valid / i_out_stall with payload o_out_item, one registered output stage
// op 0 marks a vertex present and clears its out-list, op 1 stores an edge and its
// weight, op 3 changes nothing; each gives one acknowledgement item marked last
// through ST_ACK and ST_DONE, and the next item is taken back in ST_IDLE
// op 2 runs prim from the lowest present vertex and emits (parent, child, cost)
// per extracted vertex that has a parent, last on the final one; an empty tree
// gives one item with all fields zero but last
// in a run each extraction scans all key memory entries one per cycle for the
// minimum, walks the extracted vertex's row of the weight memory one entry per
// cycle and then goes to ST_EMIT; the single read port of each memory sets this
// pace; each tree edge is held back until the next one is known or the run ends
// one item is worked on at a time; the input stalls until the item is finished
// a stalled output holds its item; the engine waits on it only to send a new item
// after reset the adjacency memory is cleared row by row with the input stalled;
// present and queued flags clear at once; the weight memory is not cleared, an
// unwritten weight is never used
module mst_prim_dense_graph_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpdg_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpdg_pkg::t_out_item o_out_item
);
    import mpdg_pkg::*;

    // weight memory, row = source vertex
    t_weight r_wmem [MaxVertices*MaxVertices];
    t_weight r_wrd;
    // key memory, one entry per vertex
    t_weight r_kmem [MaxVertices];
    t_weight r_krd;
    // parent memory, holds parent+1, zero means none
    logic [VtxBits:0] r_pmem [MaxVertices];
    logic [VtxBits:0] r_prd;
    // adjacency memory, one row of out-edge bits per source vertex
    logic [MaxVertices-1:0] r_amem [MaxVertices];
    logic [MaxVertices-1:0] r_ard;

    logic [MaxVertices-1:0] r_present, r_queued;

    t_state r_state, n_state;
    logic [VtxBits:0] r_idx, n_idx;     // scan counter, one past the top ends
    logic [VtxBits:0] r_best, n_best;   // MaxVertices = none
    t_weight r_bkey, n_bkey;
    logic r_rdv, n_rdv;                 // read data valid for r_ridx
    t_vtx r_ridx, n_ridx;
    logic r_any, n_any;                 // r_pend holds a tree edge
    logic r_ov, n_ov;
    t_out_item r_out, n_out;
    t_out_item r_pend, n_pend;          // latest tree edge, sent once the next is known
    t_in_item r_cmd;

    // memory port controls
    logic k_we, w_we, p_we, a_we;
    t_vtx k_wa, p_wa, k_ra, p_ra, a_wa, a_ra;
    t_weight k_wd, w_wd;
    logic [VtxBits:0] p_wd;
    logic [MaxVertices-1:0] a_wd;
    logic [EdgeBits-1:0] w_wa, w_ra;

    logic in_acc, out_acc;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_ov && !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    t_vtx u;
    assign u = r_best[VtxBits-1:0];

    always_ff @(posedge i_clk) begin
        if (k_we) r_kmem[k_wa] <= k_wd;
        r_krd <= r_kmem[k_ra];
        if (p_we) r_pmem[p_wa] <= p_wd;
        r_prd <= r_pmem[p_ra];
        if (w_we) r_wmem[w_wa] <= w_wd;
        r_wrd <= r_wmem[w_ra];
        if (a_we) r_amem[a_wa] <= a_wd;
        r_ard <= r_amem[a_ra];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_cmd <= i_in_item;
        r_out  <= n_out;
        r_pend <= n_pend;
        r_bkey <= n_bkey;
        r_ridx <= n_ridx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_best    <= '0;
            r_rdv     <= 1'b0;
            r_any     <= 1'b0;
            r_ov      <= 1'b0;
            r_present <= '0;
            r_queued  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_best  <= n_best;
            r_rdv   <= n_rdv;
            r_any   <= n_any;
            r_ov    <= n_ov;
            if (r_state == ST_ACK && t_op'(r_cmd.op) == OP_START_LIST)
                r_present[r_cmd.from_vertex] <= 1'b1;
            if (r_state == ST_INIT && r_idx == '0) r_queued <= r_present;
            if (r_state == ST_SCAN && r_idx[VtxBits] && !r_rdv && !r_best[VtxBits])
                r_queued[u] <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_best = r_best;
        n_bkey = r_bkey;
        n_rdv = 1'b0;
        n_ridx = r_ridx;
        n_any = r_any;
        n_ov = r_ov && i_out_stall;
        n_out = r_out;
        n_pend = r_pend;
        k_we = 1'b0; k_wa = r_idx[VtxBits-1:0]; k_wd = '1;
        p_we = 1'b0; p_wa = r_idx[VtxBits-1:0]; p_wd = '0;
        w_we = 1'b0; w_wa = {r_cmd.from_vertex, r_cmd.to_vertex}; w_wd = r_cmd.edge_cost;
        a_we = 1'b0; a_wa = r_cmd.from_vertex; a_wd = '0;
        k_ra = r_idx[VtxBits-1:0];
        p_ra = u;
        w_ra = {u, r_idx[VtxBits-1:0]};
        a_ra = u;
        unique case (r_state)
            ST_CLEAR: begin
                a_we = 1'b1;
                a_wa = r_idx[VtxBits-1:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == (VtxBits+1)'(MaxVertices - 1)) begin
                    n_state = ST_IDLE;
                    n_idx = '0;
                end
            end
            ST_IDLE: begin
                // row of the source vertex is ready for the edge update
                a_ra = i_in_item.from_vertex;
                if (in_acc) begin
                    if (t_op'(i_in_item.op) == OP_RUN_TREE) begin
                        n_state = ST_INIT;
                        n_idx = '0;
                        n_any = 1'b0;
                    end else begin
                        n_state = ST_ACK;
                    end
                end
            end
            ST_ACK: begin
                unique case (t_op'(r_cmd.op))
                    OP_START_LIST: a_we = 1'b1;
                    OP_ADD_EDGE: begin
                        w_we = 1'b1;
                        a_we = 1'b1;
                        a_wd = r_ard | (MaxVertices'(1) << r_cmd.to_vertex);
                    end
                    OP_RUN_TREE, OP_NONE: ;
                endcase
                n_state = ST_DONE;
            end
            ST_INIT: begin
                // keys to all ones except first present vertex, parents cleared
                k_we = 1'b1;
                p_we = 1'b1;
                k_wd = '1;
                if (r_present[r_idx[VtxBits-1:0]] &&
                    (r_present & ((MaxVertices'(1) << r_idx[VtxBits-1:0]) - 1'b1)) == '0)
                    k_wd = '0;
                n_idx = r_idx + 1'b1;
                if (r_idx == (VtxBits+1)'(MaxVertices - 1)) begin
                    n_state = ST_SCAN;
                    n_idx = '0;
                    n_best = (VtxBits+1)'(MaxVertices);
                end
            end
            ST_SCAN: begin
                // issue key reads, compare registered data of previous index
                if (r_rdv && r_queued[r_ridx] &&
                    (r_best[VtxBits] || r_krd < r_bkey)) begin
                    n_best = {1'b0, r_ridx};
                    n_bkey = r_krd;
                end
                if (!r_idx[VtxBits]) begin
                    n_rdv = 1'b1;
                    n_ridx = r_idx[VtxBits-1:0];
                    n_idx = r_idx + 1'b1;
                end else if (!r_rdv) begin
                    if (r_best[VtxBits]) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RELAX;
                        n_idx = '0;
                    end
                end
            end
            ST_RELAX: begin
                // issue weight row and key reads, compare the registered data of the previous index
                if (r_rdv && r_ard[r_ridx] && r_queued[r_ridx] && r_wrd < r_krd) begin
                    k_we = 1'b1; k_wa = r_ridx; k_wd = r_wrd;
                    p_we = 1'b1; p_wa = r_ridx; p_wd = {1'b0, u} + 1'b1;
                end
                if (!r_idx[VtxBits]) begin
                    n_rdv = 1'b1;
                    n_ridx = r_idx[VtxBits-1:0];
                    n_idx = r_idx + 1'b1;
                end else if (!r_rdv) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // r_prd holds parent+1 of u, zero means none
                if (r_prd == '0) begin
                    n_state = ST_SCAN;
                    n_idx = '0;
                    n_best = (VtxBits+1)'(MaxVertices);
                end else if (!r_any || !r_ov || !i_out_stall) begin
                    if (r_any) begin
                        n_ov = 1'b1;
                        n_out = r_pend;
                    end
                    n_pend.tree_parent = r_prd[VtxBits-1:0] - 1'b1;
                    n_pend.tree_child = u;
                    n_pend.tree_cost = r_bkey;
                    n_pend.edge_valid = 1'b1;
                    n_pend.last = 1'b0;
                    n_any = 1'b1;
                    n_state = ST_SCAN;
                    n_idx = '0;
                    n_best = (VtxBits+1)'(MaxVertices);
                end
            end
            ST_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_state = ST_IDLE;
                    n_ov = 1'b1;
                    if (t_op'(r_cmd.op) == OP_RUN_TREE && r_any) begin
                        n_out = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = '0;
                        n_out.last = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !o_in_stall)
        else $error("idle engine stalls input");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.edge_valid |-> o_out_item.tree_parent != o_out_item.tree_child)
        else $error("tree edge is a self loop");

endmodule
